### hdl/smu_pkg.sv
// Shared types and constants for the sort and median unit.
// No dependencies; imported by every module of the block.
package smu_pkg;

  localparam int SMU_MAX_ELEMENTS = 128;
  localparam int SMU_QUEUE_DEPTH  = 4;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int SIZE_W   = 8;

  // One input transaction as held in the queue between front and back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } smu_item_t;

endpackage

### hdl/smu_front.sv
// Front end of the sort and median unit: accepts input transactions
// and holds them in a short queue for the sort engine. Depends on smu_pkg.
module smu_front #(
  parameter int QUEUE_DEPTH = smu_pkg::SMU_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [smu_pkg::SAMPLE_W-1:0]  in_tdata,   // [31:0] sample
  input  logic                          in_tlast,   // last_sample
  output logic                          item_valid,
  input  logic                          item_ready,
  output smu_pkg::smu_item_t            item
);
  import smu_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  smu_item_t        q_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QCW-1:0]   cnt_r;
  logic             push, pop;

  assign in_tready  = (cnt_r != QCW'(QUEUE_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rp_r];
  assign push       = in_tvalid && in_tready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].sample      <= in_tdata;
      q_r[wp_r].last_sample <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

### hdl/smu_back.sv
// Back end of the sort and median unit: insertion sort into a sample memory
// with one read and one write port, median readout and the result register. Depends on smu_pkg.
module smu_back #(
  parameter int MAX_ELEMENTS = smu_pkg::SMU_MAX_ELEMENTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  smu_pkg::smu_item_t            item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [smu_pkg::MEDIAN_W-1:0] out_median,
  output logic [smu_pkg::SIZE_W-1:0]    out_size,
  output logic                          out_ovf
);
  import smu_pkg::*;

  localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CMP, S_PLACE, S_MED0, S_MED1, S_MED2
  } state_t;

  logic signed [SAMPLE_W-1:0] mem [MAX_ELEMENTS];

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [AW-1:0]               j_r, j_nxt;
  logic signed [SAMPLE_W-1:0]  cur_s_r, cur_s_nxt;
  logic                        cur_last_r, cur_last_nxt;
  logic signed [SAMPLE_W-1:0]  lo_r, lo_nxt;
  logic signed [SAMPLE_W-1:0]  rd_q_r;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [MEDIAN_W-1:0]  out_median_r, out_median_nxt;
  logic [SIZE_W-1:0]           out_size_r, out_size_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic signed [SAMPLE_W-1:0]  wr_data;
  logic [AW-1:0]               rd_addr;
  logic                        load_out;
  logic [31:0]                 cnt_ext;

  assign cnt_ext    = 32'(count_r);
  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;
  assign out_size   = out_size_r;
  assign out_ovf    = out_ovf_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    j_nxt          = j_r;
    cur_s_nxt      = cur_s_r;
    cur_last_nxt   = cur_last_r;
    lo_nxt         = lo_r;
    out_median_nxt = out_median_r;
    out_size_nxt   = out_size_r;
    out_ovf_nxt    = out_ovf_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    wr_en          = 1'b0;
    wr_addr        = j_r;
    wr_data        = cur_s_r;
    rd_addr        = j_r;
    item_ready     = 1'b0;
    load_out       = 1'b0;

    case (state_r)
      S_IDLE: begin
        item_ready = 1'b1;
        rd_addr    = AW'(count_r - CNT_W'(1));
        if (item_valid) begin
          cur_s_nxt    = item.sample;
          cur_last_nxt = item.last_sample;
          if (count_r == CNT_W'(MAX_ELEMENTS)) begin
            // store full: drop the sample
            ovf_nxt   = 1'b1;
            state_nxt = item.last_sample ? S_MED0 : S_IDLE;
          end else if (count_r == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = item.sample;
            count_nxt = CNT_W'(1);
            state_nxt = item.last_sample ? S_MED0 : S_IDLE;
          end else begin
            j_nxt     = AW'(count_r);
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        rd_addr = j_r - AW'(2);
        wr_en   = 1'b1;
        if (rd_q_r > cur_s_r) begin
          // shift the larger entry up one place
          wr_data = rd_q_r;
          j_nxt   = j_r - AW'(1);
          if (j_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = cur_last_r ? S_MED0 : S_IDLE;
        end
      end
      S_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = cur_last_r ? S_MED0 : S_IDLE;
      end
      S_MED0: begin
        rd_addr   = AW'((count_r - CNT_W'(1)) >> 1);
        state_nxt = S_MED1;
      end
      S_MED1: begin
        rd_addr   = AW'(count_r >> 1);
        lo_nxt    = rd_q_r;
        state_nxt = S_MED2;
      end
      S_MED2: begin
        // odd count reads the middle twice, so the sum is its double
        rd_addr = AW'(count_r >> 1);
        if (!out_valid_r || out_ready) begin
          load_out       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_median_nxt = {lo_r[SAMPLE_W-1], lo_r} + {rd_q_r[SAMPLE_W-1], rd_q_r};
          out_size_nxt   = cnt_ext[SIZE_W-1:0];
          out_ovf_nxt    = ovf_r;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      j_r         <= '0;
      cur_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      j_r         <= j_nxt;
      cur_last_r  <= cur_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_s_r      <= cur_s_nxt;
    lo_r         <= lo_nxt;
    out_median_r <= out_median_nxt;
    out_size_r   <= out_size_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMENTS))
    else $error("stored count above capacity");

  a_cmp_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (j_r != '0) && (CNT_W'(j_r) <= count_r))
    else $error("insertion index out of range");

  a_no_write_in_median: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MED0 || state_r == S_MED1 || state_r == S_MED2) |-> !wr_en)
    else $error("store written during median readout");

  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (count_r == '0) && !ovf_r && out_valid_r)
    else $error("set not cleared after result");

endmodule

### hdl/sort_and_median_unit.sv
// Sort and median unit: an input queue feeding a sequential insertion-sort engine over
// a dual-port sample memory (one read, one write). Depends on smu_pkg, smu_front, smu_back.
//
// Samples arrive one per input transaction; in_tlast marks the last sample of a
// set. Each kept sample is inserted in ascending order into a MAX_ELEMENTS-deep
// memory, one entry shifted per clock: an item is written to entry 0 when the store
// is empty and dropped when it is full, and otherwise each stored entry larger
// than it is shifted up one place before it is written. After the last sample
// the middle entries are read and the result is loaded. The result carries
// twice the median (sum of the two middle entries, or the middle entry doubled),
// the kept count and an overflow flag set when samples beyond capacity were dropped.
// A four-entry input queue and a result register let either side stall independently.
module sort_and_median_unit #(
  parameter int MAX_ELEMENTS = smu_pkg::SMU_MAX_ELEMENTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tlast,   // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [32:0] median_doubled, [40:33] set_size, rest zero
  output logic [0:0]  out_tuser   // [0] overflowed
);
  import smu_pkg::*;

  smu_item_t                  item;
  logic                       item_valid, item_ready;
  logic signed [MEDIAN_W-1:0] median;
  logic [SIZE_W-1:0]          size;
  logic                       ovf;

  smu_front #(
    .QUEUE_DEPTH (SMU_QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  smu_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_median (median),
    .out_size   (size),
    .out_ovf    (ovf)
  );

  assign out_tdata = {7'd0, size, median};
  assign out_tuser = ovf;

endmodule

### bench/tb_top.sv
// Self-checking bench for sort_and_median_unit: streams sets of signed samples,
// predicts each doubled median, and checks every result transaction.
// Depends on smu_pkg (store depth, field widths) and the sort_and_median_unit RTL.
module tb_top;
  import smu_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD    = 200;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CALM_TAIL    = 300;
  localparam int MAX_REPORTED = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  typedef struct {
    logic [MEDIAN_W-1:0] median_x2;
    logic [SIZE_W-1:0]   set_size;
    logic                overflowed;
  } median_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;

  // Model state: kept samples of the open set in ascending order.
  logic signed [SAMPLE_W-1:0] sorted_samples[$];
  logic                       set_dropped = 1'b0;
  median_result_t             pending_medians[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  send_gaps_on = 1'b0;
  bit  recv_stalls_on = 1'b0;
  bit  hold_request = 1'b0;

  sort_and_median_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTED)
      $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Insert or drop one accepted sample; on the last one of a set, queue its median.
  function automatic void track_median(input logic signed [SAMPLE_W-1:0] s,
                                       input logic is_last);
    int             pos;
    int             cnt;
    longint         sum;
    median_result_t res;
    if (sorted_samples.size() < SMU_MAX_ELEMENTS) begin
      pos = sorted_samples.size();
      while (pos > 0 && sorted_samples[pos-1] > s)
        pos--;
      sorted_samples.insert(pos, s);
    end else begin
      set_dropped = 1'b1;
    end
    if (is_last) begin
      cnt = sorted_samples.size();
      if (cnt % 2 == 0)
        sum = longint'(sorted_samples[(cnt-1)/2]) + longint'(sorted_samples[cnt/2]);
      else
        sum = 2 * longint'(sorted_samples[cnt/2]);
      res.median_x2  = sum[MEDIAN_W-1:0];
      res.set_size   = cnt[SIZE_W-1:0];
      res.overflowed = set_dropped;
      pending_medians.push_back(res);
      sorted_samples.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // Call at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    track_median(s, is_last);
  endtask

  task automatic send_set(input logic signed [SAMPLE_W-1:0] vals[$]);
    foreach (vals[i])
      send_sample(vals[i], i == vals.size() - 1);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3, 4: return $signed(32'($urandom_range(0, 15))) - 8;
      default: return $signed($urandom);
    endcase
  endfunction

  // Result side: random stall bursts, plus one long hold on request.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0)
        stall_left--;
      else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (recv_stalls_on && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 4);
      out_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin : check_results
    median_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_medians.size() == 0) begin
        flag_error($sformatf("result with no set pending: tdata=%h tuser=%b",
                             out_tdata, out_tuser));
      end else begin
        want = pending_medians.pop_front();
        if (out_tdata[32:0] !== want.median_x2)
          flag_error($sformatf("median_doubled exp %0d got %0d",
                               $signed(want.median_x2), $signed(out_tdata[32:0])));
        if (out_tdata[40:33] !== want.set_size)
          flag_error($sformatf("set_size exp %0d got %0d", want.set_size, out_tdata[40:33]));
        if (out_tdata[47:41] !== '0)
          flag_error($sformatf("tdata padding exp 0 got %h", out_tdata[47:41]));
        if (out_tuser[0] !== want.overflowed)
          flag_error($sformatf("overflowed exp %b got %b", want.overflowed, out_tuser[0]));
      end
    end
  end

  task automatic test_extremes();
    send_set('{SAMPLE_MAX});
    send_set('{SAMPLE_MIN});
    send_set('{SAMPLE_MAX, SAMPLE_MAX});
    send_set('{SAMPLE_MIN, SAMPLE_MIN});
    send_set('{SAMPLE_MAX, SAMPLE_MIN});
    send_set('{32'sd0});
    send_set('{-32'sd1});
    send_set('{32'sd5, -32'sd3, 32'sd7});
    send_set('{32'sd9, -32'sd2, 32'sd4, 32'sd9});
  endtask

  // Fill the store exactly, then overrun it including a dropped last sample.
  task automatic test_overflow();
    logic signed [SAMPLE_W-1:0] vals[$];
    for (int i = 0; i < SMU_MAX_ELEMENTS; i++)
      vals.push_back(SAMPLE_MAX - i);
    send_set(vals);
    vals.delete();
    for (int i = 0; i <= SMU_MAX_ELEMENTS; i++)
      vals.push_back(SAMPLE_MIN + i);
    send_set(vals);
    vals.delete();
    for (int i = 0; i < SMU_MAX_ELEMENTS + 7; i++)
      vals.push_back(random_sample());
    send_set(vals);
  endtask

  // Stall the result side for a long stretch while single-sample sets keep coming.
  task automatic test_backpressure();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_request   = 1'b1;
    for (int i = 0; i < 40; i++)
      send_sample(random_sample(), 1'b1);
  endtask

  task automatic test_random();
    int sent;
    int set_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
      end else begin
        send_gaps_on   = ($urandom_range(0, 4) != 0);
        recv_stalls_on = ($urandom_range(0, 4) != 0);
      end
      case ($urandom_range(0, 19))
        0:       set_len = $urandom_range(SMU_MAX_ELEMENTS - 8, SMU_MAX_ELEMENTS + 12);
        1, 2:    set_len = $urandom_range(13, 64);
        default: set_len = $urandom_range(1, 12);
      endcase
      for (int i = 0; i < set_len; i++)
        send_sample(random_sample(), i == set_len - 1);
      sent += set_len;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    test_extremes();
    test_overflow();
    test_backpressure();
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    test_random();
    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
